@@ sv/keyed_stock_accumulate_table_core_macros.svh @@
// Assertion macros for the keyed stock table core.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef KEYED_STOCK_ACCUMULATE_TABLE_CORE_MACROS_SVH
`define KEYED_STOCK_ACCUMULATE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/kst_pkg.sv @@
// Shared types, codes and helpers for the keyed stock table core.
// No dependencies; imported by every module of the block.
package kst_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int IDX_W       = 6;   // covers ENTRIES up to 64
  localparam int CNT_W       = 7;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_PURCHASE = 2'd1;
  localparam logic [1:0] OP_MAX      = 2'd2;
  localparam logic [1:0] OP_TOTALS   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_KEY   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam logic [1:0] CLS_R = 2'd0;
  localparam logic [1:0] CLS_Q = 2'd1;
  localparam logic [1:0] CLS_A = 2'd2;

  localparam logic [9:0] KEY_LOW  = 10'd100;
  localparam logic [9:0] KEY_HIGH = 10'd999;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  item_key;
    logic [1:0]  item_class;
    logic [31:0] quantity;
    logic [31:0] initial_stock;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  found_key;
    logic [31:0] stock_value;
    logic [39:0] total_r;
    logic [39:0] total_q;
    logic [39:0] total_a;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [9:0]  key;
    logic [1:0]  cls;
    logic [31:0] bought;
    logic [31:0] stock;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_t status_only(input logic [2:0] st);
    out_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

@@ sv/kst_store.sv @@
// Record memory of the keyed stock table: one write and one registered read port.
// Depends on kst_pkg for the entry and request types.
module kst_store import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    // hold read data when no read is issued
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

@@ sv/kst_ctrl.sv @@
// Sequencer of the keyed stock table: scans the record memory, updates it and
// drives the result register. Depends on kst_pkg.
module kst_ctrl import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_t      in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data,
  output mem_req_t mem_req,
  input  entry_t   rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;
  localparam logic [2:0] S_MRD  = 3'd5;
  localparam logic [2:0] S_MCMP = 3'd6;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  logic [2:0]       state;
  in_t              req;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [31:0]      mx;
  logic [IDX_W-1:0] last_idx;
  logic [39:0]      tr, tq, ta;
  out_t             res;

  logic        slot_free;
  logic        key_hit;
  logic        max_hit;
  logic        out_load;
  out_t        out_next;
  out_t        hit_res;
  out_t        sums_res;
  logic [31:0] bought_next;
  logic [31:0] stock_next;

  assign in_ready    = (state == S_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign key_hit     = (rd_data.key == req.item_key);
  assign max_hit     = (rd_data.stock == mx);
  assign bought_next = sat_add32(rd_data.bought, req.quantity);
  assign stock_next  = sat_add32(rd_data.stock, req.quantity);

  always_comb begin
    hit_res             = status_only(ST_OK);
    hit_res.found_key   = req.item_key;
    hit_res.stock_value = stock_next;
    sums_res            = status_only(ST_OK);
    sums_res.total_r    = tr;
    sums_res.total_q    = tq;
    sums_res.total_a    = ta;
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = ((state == S_RD) && (idx != count)) || (state == S_MRD);
    mem_req.rd_addr = idx[IDX_W-1:0];
    if ((state == S_CMP) && (req.opcode == OP_PURCHASE) && key_hit) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = idx[IDX_W-1:0];
      mem_req.wr_data = '{key: rd_data.key, cls: rd_data.cls,
                          bought: bought_next, stock: stock_next};
    end else if ((state == S_END) && (req.opcode == OP_LOAD) && (count != FULL_CNT)) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = count[IDX_W-1:0];
      mem_req.wr_data = '{key: req.item_key, cls: req.item_class,
                          bought: req.quantity, stock: req.initial_stock};
    end
  end

  always_comb begin
    out_next             = '0;
    out_next.status      = ST_OK;
    out_next.found_key   = rd_data.key;
    out_next.stock_value = mx;
    out_next.last        = (idx[IDX_W-1:0] == last_idx);
    out_load             = 1'b0;
    if (state == S_RESP) begin
      out_next = res;
      out_load = slot_free;
    end else if ((state == S_MCMP) && max_hit) begin
      out_load = slot_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            idx      <= '0;
            mx       <= '0;
            last_idx <= '0;
            tr       <= '0;
            tq       <= '0;
            ta       <= '0;
            if ((in_data.opcode == OP_LOAD) &&
                ((in_data.item_key < KEY_LOW) || (in_data.item_key > KEY_HIGH))) begin
              res   <= status_only(ST_BAD_KEY);
              state <= S_RESP;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= (idx == count) ? S_END : S_CMP;
        end
        S_CMP: begin
          case (req.opcode)
            OP_LOAD: begin
              if (key_hit) begin
                res   <= status_only(ST_DUPLICATE);
                state <= S_RESP;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            OP_PURCHASE: begin
              if (key_hit) begin
                res   <= hit_res;
                state <= S_RESP;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            OP_MAX: begin
              idx   <= idx + 1'b1;
              state <= S_RD;
              // keep the position of the latest record at the running maximum
              if ((idx == '0) || (rd_data.stock > mx)) begin
                mx       <= rd_data.stock;
                last_idx <= idx[IDX_W-1:0];
              end else if (max_hit) begin
                last_idx <= idx[IDX_W-1:0];
              end
            end
            default: begin
              idx   <= idx + 1'b1;
              state <= S_RD;
              // at most 64 terms of 32 bits: the 40-bit sums cannot overflow
              case (rd_data.cls)
                CLS_R:   tr <= tr + {8'd0, rd_data.bought};
                CLS_Q:   tq <= tq + {8'd0, rd_data.bought};
                CLS_A:   ta <= ta + {8'd0, rd_data.bought};
                default: ;
              endcase
            end
          endcase
        end
        S_END: begin
          case (req.opcode)
            OP_LOAD: begin
              state <= S_RESP;
              if (count == FULL_CNT) begin
                res <= status_only(ST_FULL);
              end else begin
                res   <= status_only(ST_OK);
                count <= count + 1'b1;
              end
            end
            OP_PURCHASE: begin
              res   <= status_only(ST_NOT_FOUND);
              state <= S_RESP;
            end
            OP_MAX: begin
              if (count == '0) begin
                res   <= status_only(ST_EMPTY);
                state <= S_RESP;
              end else begin
                idx   <= '0;
                state <= S_MRD;
              end
            end
            default: begin
              res   <= sums_res;
              state <= S_RESP;
            end
          endcase
        end
        S_MRD: begin
          state <= S_MCMP;
        end
        S_MCMP: begin
          if (!max_hit) begin
            idx   <= idx + 1'b1;
            state <= S_MRD;
          end else if (slot_free) begin
            if (idx[IDX_W-1:0] == last_idx) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_MRD;
            end
          end
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register: parts the receiver from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

@@ sv/keyed_stock_accumulate_table_core.sv @@
// Keyed stock table: up to ENTRIES records of key, class, purchased total, stock.
//
// Input channel in_valid/in_ready/in_data carries one operation per transaction:
// load, purchase, max stock query or class totals query. Output channel
// out_valid/out_ready/out_data carries results; last marks the final result of
// an operation. Only a max query can give more than one result.
// One operation is in flight at a time; in_ready is high only when idle.
// The records live in one synchronous memory (one read, one write port), scanned
// one entry at a time (read state, then compare state), so for n stored records:
//   load or purchase: scans all n records, less on an early hit or a bad load key;
//   totals query: scans all n records;
//   max query: a search pass over all n records, then a second pass up to the
//   last record at the maximum.
// Results leave through a result register; a stalled receiver holds the scan at
// the next result while the register stays full, and a finished operation lets
// the next one in while its result still waits.
// Reset empties the table at once (record count to zero); memory contents need
// no clearing, as only entries below the count are read.
// Depends on kst_pkg, kst_ctrl, kst_store and the assertion macro header.
`include "keyed_stock_accumulate_table_core_macros.svh"

module keyed_stock_accumulate_table_core import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  mem_req_t mem_req;
  entry_t   rd_data;
  logic     rej_result;
  logic     rej_clean;

  kst_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  kst_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign rej_result = out_valid &&
                      (out_data.status inside {ST_DUPLICATE, ST_FULL, ST_BAD_KEY, ST_EMPTY});
  assign rej_clean  = out_data.last && (out_data.found_key == '0) &&
                      (out_data.stock_value == '0);

  `KST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `KST_ASSERT_NOW(a_multi_result_busy, out_valid && !out_data.last, !in_ready, "input open early")
  `KST_ASSERT_NOW(a_reject_single, rej_result, rej_clean, "rejection result malformed")

endmodule
